>>> rtl/core/c3vs_pkg.sv
// ----------------------------------------------------------------------------
// c3vs_pkg
// Shared widths, register indexes and types for the 3x3 valid convolution.
// ----------------------------------------------------------------------------
package c3vs_pkg;

    localparam int LINE_MAX_DEF = 1024;   // default line store depth
    localparam int HEIGHT_MAX   = 4096;   // largest frame height

    localparam int PIX_W      = 16;
    localparam int WIDTH_W    = 11;
    localparam int HEIGHT_W   = 13;
    localparam int ROW_W      = 12;
    localparam int COEF_W     = 48;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_ADDR_W = 3;
    localparam int PROD_W     = 32;
    localparam int ROWSUM_W   = 34;
    localparam int RESULT_W   = 36;
    localparam int KERN_N     = 3;
    localparam int WIN_N      = KERN_N * KERN_N;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_TOP     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_MIDDLE  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_COEF_BOTTOM  = 3'd4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd8;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd8;

    typedef logic signed [PIX_W-1:0]      pix_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0]  win_t;   // index = row*3 + col, col 2 newest
    typedef logic [COEF_W-1:0]            coef_row_t;

    // per-request tag that follows a result down the pipe
    typedef struct packed {
        logic [ROW_W-1:0] row;    // output row
        logic             last;   // last result of the frame
    } meta_t;

endpackage

>>> rtl/core/c3vs_line_buf.sv
// ----------------------------------------------------------------------------
// c3vs_line_buf
// Two-line pixel store in one dual-port memory plus the 3x3 window register.
// ----------------------------------------------------------------------------
module c3vs_line_buf #(
    parameter int LINE_MAX = c3vs_pkg::LINE_MAX_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [$clog2(LINE_MAX)-1:0]  in_idx,
    input  c3vs_pkg::pix_t               in_pixel,
    input  logic                         in_produce,
    input  c3vs_pkg::meta_t              in_meta,
    input  logic [$clog2(LINE_MAX)-1:0]  in_col,
    output logic                         win_valid,
    input  logic                         win_ready,
    output c3vs_pkg::win_t               win,
    output c3vs_pkg::meta_t              win_meta,
    output logic [$clog2(LINE_MAX)-1:0]  win_col
);
    import c3vs_pkg::*;

    localparam int COL_W  = $clog2(LINE_MAX);
    localparam int PAIR_W = 2 * PIX_W;

    // {older line, newer line} per column
    logic [PAIR_W-1:0] line_mem [LINE_MAX];

    logic [PAIR_W-1:0] rd_reg;
    logic              fwd_reg;
    logic [PAIR_W-1:0] fwd_data_reg;

    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_idx_reg;
    pix_t              s1_px_reg;
    logic              s1_prod_reg;
    meta_t             s1_meta_reg;
    logic [COL_W-1:0]  s1_col_reg;

    win_t              win_reg;
    logic              win_valid_reg;
    meta_t             win_meta_reg;
    logic [COL_W-1:0]  win_col_reg;

    logic              s1_adv;
    logic              s2_adv;
    logic              acc;
    logic [PAIR_W-1:0] pair;
    logic [PIX_W-1:0]  older;
    logic [PIX_W-1:0]  newer;
    logic [PAIR_W-1:0] wr_data;

    assign s2_adv   = win_valid_reg && win_ready;
    assign s1_adv   = s1_valid_reg && (!win_valid_reg || s2_adv);
    assign in_ready = !s1_valid_reg || s1_adv;
    assign acc      = in_valid && in_ready;

    // bypass when the write of the request ahead hits the same column
    assign pair    = fwd_reg ? fwd_data_reg : rd_reg;
    assign older   = pair[PAIR_W-1:PIX_W];
    assign newer   = pair[PIX_W-1:0];
    assign wr_data = {newer, s1_px_reg};

    always_ff @(posedge aclk) begin
        if (acc) begin
            rd_reg <= line_mem[in_idx];
        end
        if (s1_adv) begin
            line_mem[s1_idx_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            win_valid_reg <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            if (acc) begin
                s1_valid_reg <= 1'b1;
                fwd_reg      <= s1_adv && (in_idx == s1_idx_reg);
            end else if (s1_adv) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv) begin
                win_valid_reg <= s1_prod_reg;
            end else if (s2_adv) begin
                win_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            s1_idx_reg   <= in_idx;
            s1_px_reg    <= in_pixel;
            s1_prod_reg  <= in_produce;
            s1_meta_reg  <= in_meta;
            s1_col_reg   <= in_col;
            fwd_data_reg <= wr_data;
        end
        if (s1_adv) begin
            for (int r = 0; r < KERN_N; r++) begin
                for (int c = 0; c < KERN_N - 1; c++) begin
                    win_reg[r*KERN_N + c] <= win_reg[r*KERN_N + c + 1];
                end
            end
            win_reg[KERN_N-1]          <= older;
            win_reg[2*KERN_N-1]        <= newer;
            win_reg[WIN_N-1]           <= s1_px_reg;
            win_meta_reg               <= s1_meta_reg;
            win_col_reg                <= s1_col_reg;
        end
    end

    assign win_valid = win_valid_reg;
    assign win       = win_reg;
    assign win_meta  = win_meta_reg;
    assign win_col   = win_col_reg;

`ifndef ASSERT_OFF
    a_s1_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_adv |=> s1_valid_reg && $stable(s1_idx_reg))
        else $error("line stage lost a held request");

    a_win_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        win_valid_reg && !win_ready |=> win_valid_reg && $stable(win_reg))
        else $error("window shifted under a stalled result");
`endif

endmodule

>>> rtl/core/c3vs_mac.sv
// ----------------------------------------------------------------------------
// c3vs_mac
// Nine-tap multiply-accumulate: products, row sums, final sum / output reg.
// ----------------------------------------------------------------------------
module c3vs_mac #(
    parameter int LINE_MAX = c3vs_pkg::LINE_MAX_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  c3vs_pkg::win_t                         in_win,
    input  c3vs_pkg::meta_t                        in_meta,
    input  logic [$clog2(LINE_MAX)-1:0]            in_col,
    input  c3vs_pkg::coef_row_t                    coef_top,
    input  c3vs_pkg::coef_row_t                    coef_mid,
    input  c3vs_pkg::coef_row_t                    coef_bot,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [c3vs_pkg::RESULT_W-1:0]   m_conv_value,
    output logic [c3vs_pkg::ROW_W-1:0]             m_out_row,
    output logic [$clog2(LINE_MAX)-1:0]            m_out_col,
    output logic                                   m_frame_end
);
    import c3vs_pkg::*;

    localparam int COL_W = $clog2(LINE_MAX);

    logic [KERN_N-1:0][COEF_W-1:0] coef_all;

    logic signed [PROD_W-1:0]   prod_reg [WIN_N];
    logic                       p_valid_reg;
    meta_t                      p_meta_reg;
    logic [COL_W-1:0]           p_col_reg;

    logic signed [ROWSUM_W-1:0] rsum_reg [KERN_N];
    logic                       r_valid_reg;
    meta_t                      r_meta_reg;
    logic [COL_W-1:0]           r_col_reg;

    logic signed [RESULT_W-1:0] o_value_reg;
    logic                       o_valid_reg;
    meta_t                      o_meta_reg;
    logic [COL_W-1:0]           o_col_reg;

    logic en_p;
    logic en_r;
    logic en_o;

    assign coef_all = {coef_bot, coef_mid, coef_top};

    assign en_o     = !o_valid_reg || m_ready;
    assign en_r     = !r_valid_reg || en_o;
    assign en_p     = !p_valid_reg || en_r;
    assign in_ready = en_p;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (en_p) begin
                p_valid_reg <= in_valid;
            end
            if (en_r) begin
                r_valid_reg <= p_valid_reg;
            end
            if (en_o) begin
                o_valid_reg <= r_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_p && in_valid) begin
            for (int r = 0; r < KERN_N; r++) begin
                for (int c = 0; c < KERN_N; c++) begin
                    prod_reg[r*KERN_N + c] <= $signed(in_win[r*KERN_N + c])
                                            * $signed(coef_all[r][c*PIX_W +: PIX_W]);
                end
            end
            p_meta_reg <= in_meta;
            p_col_reg  <= in_col;
        end
        if (en_r && p_valid_reg) begin
            for (int r = 0; r < KERN_N; r++) begin
                rsum_reg[r] <= ROWSUM_W'(prod_reg[r*KERN_N])
                             + ROWSUM_W'(prod_reg[r*KERN_N + 1])
                             + ROWSUM_W'(prod_reg[r*KERN_N + 2]);
            end
            r_meta_reg <= p_meta_reg;
            r_col_reg  <= p_col_reg;
        end
        if (en_o && r_valid_reg) begin
            o_value_reg <= RESULT_W'(rsum_reg[0]) + RESULT_W'(rsum_reg[1])
                         + RESULT_W'(rsum_reg[2]);
            o_meta_reg  <= r_meta_reg;
            o_col_reg   <= r_col_reg;
        end
    end

    assign m_valid      = o_valid_reg;
    assign m_conv_value = o_value_reg;
    assign m_out_row    = o_meta_reg.row;
    assign m_out_col    = o_col_reg;
    assign m_frame_end  = o_meta_reg.last;

`ifndef ASSERT_OFF
    a_enter_prod: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid && in_ready |=> p_valid_reg)
        else $error("accepted window did not reach the product stage");
`endif

endmodule

>>> rtl/core/conv3x3_valid_stream_top.sv
// ----------------------------------------------------------------------------
// conv3x3_valid_stream_top
// 3x3 valid-region convolution of a raster pixel stream, one pixel per clock when not stalled.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake          Payload
//  s_       in         s_valid/s_ready    s_pixel, s_frame_start
//  m_       out        m_valid/m_ready    m_conv_value, m_out_row, m_out_col,
//                                         m_frame_end
//  cfg_     in         cfg_we             cfg_addr, cfg_wdata
//
//  One pixel request per clock sustained while m_ready does not stall the pipe;
//  the line memory does one read and one write per clock, which sets that rate.
//  Line read happens at the accepting edge; the result then passes the window,
//  product, row-sum and final-sum registers before it is valid on the m_ channel.
//  Synchronous active-low reset clears counters, pipe valids and config registers;
//  the line memory is not cleared and needs no clearing pass.
//  m_ready low stalls the pipe from the back; bubbles are squeezed out, so
//  s_ready stays high while any stage ahead of the stall is free.
// ----------------------------------------------------------------------------
module conv3x3_valid_stream_top #(
    parameter int LINE_MAX = c3vs_pkg::LINE_MAX_DEF
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // pixel input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [c3vs_pkg::PIX_W-1:0]      s_pixel,
    input  logic                                   s_frame_start,
    // result output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [c3vs_pkg::RESULT_W-1:0]   m_conv_value,
    output logic [c3vs_pkg::ROW_W-1:0]             m_out_row,
    output logic [$clog2(LINE_MAX)-1:0]            m_out_col,
    output logic                                   m_frame_end,
    // register write port
    input  logic                                   cfg_we,
    input  logic [c3vs_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [c3vs_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
    import c3vs_pkg::*;

    localparam int COL_W = $clog2(LINE_MAX);
    localparam logic [HEIGHT_W-1:0] LINE_MAX_H   = HEIGHT_W'(LINE_MAX);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX_H = HEIGHT_W'(HEIGHT_MAX);
    localparam logic [HEIGHT_W-1:0] KERN_H       = HEIGHT_W'(KERN_N);

    // configuration registers
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    coef_row_t           coef_top_reg;
    coef_row_t           coef_mid_reg;
    coef_row_t           coef_bot_reg;

    // raster position of the next pixel
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [ROW_W-1:0]    row_reg;
    logic [ROW_W-1:0]    row_next;

    logic [HEIGHT_W-1:0] width_ext;
    logic [COL_W-1:0]    w_last;
    logic [ROW_W-1:0]    h_last;
    logic [COL_W-1:0]    col_cur;
    logic [ROW_W-1:0]    row_cur;
    logic                at_row_end;
    logic                at_last_row;
    logic                produce;
    logic                s_accept;
    meta_t               in_meta;
    logic [COL_W-1:0]    in_col;

    logic                win_valid;
    logic                win_ready;
    win_t                win;
    meta_t               win_meta;
    logic [COL_W-1:0]    win_col;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= WIDTH_RST;
            height_reg   <= HEIGHT_RST;
            coef_top_reg <= '0;
            coef_mid_reg <= '0;
            coef_bot_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_IMAGE_WIDTH: begin
                    width_reg <= cfg_wdata[WIDTH_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    height_reg <= cfg_wdata[HEIGHT_W-1:0];
                end
                REG_COEF_TOP: begin
                    coef_top_reg <= cfg_wdata[COEF_W-1:0];
                end
                REG_COEF_MIDDLE: begin
                    coef_mid_reg <= cfg_wdata[COEF_W-1:0];
                end
                REG_COEF_BOTTOM: begin
                    coef_bot_reg <= cfg_wdata[COEF_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // last column / row index, width and height clamped to the legal range
    assign width_ext = HEIGHT_W'(width_reg);

    always_comb begin
        priority if (width_ext < KERN_H) begin
            w_last = COL_W'(KERN_N - 1);
        end else if (width_ext > LINE_MAX_H) begin
            w_last = COL_W'(LINE_MAX - 1);
        end else begin
            w_last = COL_W'(width_ext - 1'b1);
        end
        priority if (height_reg < KERN_H) begin
            h_last = ROW_W'(KERN_N - 1);
        end else if (height_reg > HEIGHT_MAX_H) begin
            h_last = ROW_W'(HEIGHT_MAX - 1);
        end else begin
            h_last = ROW_W'(height_reg - 1'b1);
        end
    end

    // frame start restarts counters at this pixel; line contents are kept
    assign col_cur     = s_frame_start ? '0 : col_reg;
    assign row_cur     = s_frame_start ? '0 : row_reg;
    assign at_row_end  = col_cur >= w_last;
    assign at_last_row = row_cur >= h_last;

    always_comb begin
        if (at_row_end) begin
            col_next = '0;
            row_next = at_last_row ? '0 : ROW_W'(row_cur + 1'b1);
        end else begin
            col_next = COL_W'(col_cur + 1'b1);
            row_next = row_cur;
        end
    end

    // a window is complete once two full rows and two columns are behind it
    assign produce      = (row_cur >= ROW_W'(KERN_N - 1)) && (col_cur >= COL_W'(KERN_N - 1));
    assign in_meta.row  = ROW_W'(row_cur - ROW_W'(KERN_N - 1));
    assign in_meta.last = at_row_end && at_last_row;
    assign in_col       = COL_W'(col_cur - COL_W'(KERN_N - 1));

    assign s_accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    c3vs_line_buf #(
        .LINE_MAX (LINE_MAX)
    ) u_line_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_idx     (col_cur),
        .in_pixel   (s_pixel),
        .in_produce (produce),
        .in_meta    (in_meta),
        .in_col     (in_col),
        .win_valid  (win_valid),
        .win_ready  (win_ready),
        .win        (win),
        .win_meta   (win_meta),
        .win_col    (win_col)
    );

    c3vs_mac #(
        .LINE_MAX (LINE_MAX)
    ) u_mac (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (win_valid),
        .in_ready     (win_ready),
        .in_win       (win),
        .in_meta      (win_meta),
        .in_col       (win_col),
        .coef_top     (coef_top_reg),
        .coef_mid     (coef_mid_reg),
        .coef_bot     (coef_bot_reg),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_conv_value (m_conv_value),
        .m_out_row    (m_out_row),
        .m_out_col    (m_out_col),
        .m_frame_end  (m_frame_end)
    );

`ifndef ASSERT_OFF
    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_frame_start |=> col_reg == COL_W'(1) && row_reg == '0)
        else $error("frame start did not restart the raster counters");
`endif

endmodule

>>> sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 3x3 valid-region convolution stream.
// Every accepted pixel steps an internal copy of the line stores, window and
// row/column counters. Each window that lies inside the image queues the
// expected sum, output row, output column and frame-end flag. Each result
// taken from the block is compared with the oldest queued one. Directed tests
// cover reset values, product extremes, size saturation, restarts and
// register changes mid-frame. A random run follows under varying back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import c3vs_pkg::*;

    localparam int LINE_DEPTH     = LINE_MAX_DEF;
    localparam int COL_W          = $clog2(LINE_DEPTH);
    localparam int PIPE_LATENCY   = 5;                  // pixel to result, in clocks
    localparam int SETTLE_CYCLES  = 4 * PIPE_LATENCY;   // quiet time before a reg write
    localparam int STALL_LIMIT    = 10000;              // cycles with no transfer at all
    localparam int RANDOM_ITEMS   = 900;
    localparam int MAX_REPORTS    = 100;
    localparam int MAX_RAND_WIDTH = 40;                 // widest random frame

    // one expected output of the block
    typedef struct {
        logic signed [RESULT_W-1:0] value;
        logic [ROW_W-1:0]           row;
        logic [COL_W-1:0]           col;
        logic                       last;
    } conv_result_t;

    // ------------------------------------------------------------------------
    // DUT signals; all inputs start at known values
    // ------------------------------------------------------------------------
    logic                         aclk          = 1'b0;
    logic                         aresetn       = 1'b0;
    logic                         s_valid       = 1'b0;
    logic                         s_ready;
    pix_t                         s_pixel       = '0;
    logic                         s_frame_start = 1'b0;
    logic                         m_valid;
    logic                         m_ready       = 1'b0;
    logic signed [RESULT_W-1:0]   m_conv_value;
    logic [ROW_W-1:0]             m_out_row;
    logic [COL_W-1:0]             m_out_col;
    logic                         m_frame_end;
    logic                         cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0]        cfg_addr      = '0;
    logic [CFG_DATA_W-1:0]        cfg_wdata     = '0;

    conv3x3_valid_stream_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_pixel       (s_pixel),
        .s_frame_start (s_frame_start),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_conv_value  (m_conv_value),
        .m_out_row     (m_out_row),
        .m_out_col     (m_out_col),
        .m_frame_end   (m_frame_end),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    // 10 ns clock
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Convolution predictor state: registers, line stores, window, counters
    // ------------------------------------------------------------------------
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    coef_row_t           coef_reg [KERN_N];      // 0 = top kernel row
    pix_t                line_older [LINE_DEPTH];
    pix_t                line_newer [LINE_DEPTH];
    pix_t                win_px [KERN_N][KERN_N]; // [kernel row][col], col 2 newest
    logic [COL_W-1:0]    col_pos;
    logic [ROW_W-1:0]    row_pos;

    conv_result_t        expected_results [$];
    int                  fail_count    = 0;
    int                  pixels_sent   = 0;
    int                  src_idle_pct  = 33;
    int                  sink_idle_pct = 66;
    int                  stall_cycles  = 0;

    function automatic void clear_model();
        width_reg  = WIDTH_RST;
        height_reg = HEIGHT_RST;
        for (int k = 0; k < KERN_N; k++) begin
            coef_reg[k] = '0;
            for (int j = 0; j < KERN_N; j++) win_px[k][j] = '0;
        end
        for (int i = 0; i < LINE_DEPTH; i++) begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        col_pos = '0;
        row_pos = '0;
    endfunction

    // sizes as the block uses them: width saturates to [3, LINE_DEPTH],
    // height to [3, HEIGHT_MAX]
    function automatic int unsigned eff_width();
        int unsigned w;
        w = width_reg;
        if (w < 3) w = 3;
        if (w > LINE_DEPTH) w = LINE_DEPTH;
        return w;
    endfunction

    function automatic int unsigned eff_height();
        int unsigned h;
        h = height_reg;
        if (h < 3) h = 3;
        if (h > HEIGHT_MAX) h = HEIGHT_MAX;
        return h;
    endfunction

    // step the predictor by one accepted pixel; queue a result when the
    // window sits fully inside the image
    function automatic void advance_model(input pix_t pix, input logic fs);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  idx;
        pix_t         above;
        pix_t         above2;
        pix_t         tap;
        longint       acc;
        conv_result_t res;
        w = eff_width();
        h = eff_height();
        if (fs) begin
            col_pos = '0;
            row_pos = '0;
        end
        c   = col_pos;
        r   = row_pos;
        idx = c % LINE_DEPTH;

        above2          = line_older[idx];
        above           = line_newer[idx];
        line_older[idx] = above;
        line_newer[idx] = pix;

        for (int k = 0; k < KERN_N; k++) begin
            win_px[k][0] = win_px[k][1];
            win_px[k][1] = win_px[k][2];
        end
        win_px[0][2] = above2;
        win_px[1][2] = above;
        win_px[2][2] = pix;

        if (r >= 2 && c >= 2) begin
            acc = 0;
            for (int k = 0; k < KERN_N; k++) begin
                for (int j = 0; j < KERN_N; j++) begin
                    tap = coef_reg[k][PIX_W*j +: PIX_W];  // left tap in low bits
                    acc += longint'(tap) * longint'(win_px[k][j]);
                end
            end
            res.value = acc[RESULT_W-1:0];
            res.row   = ROW_W'(r - 2);
            res.col   = COL_W'(c - 2);
            res.last  = (r >= h - 1) && (c >= w - 1);
            expected_results.push_back(res);
        end

        // counters at or past the last column/row wrap, also after a size change
        if (c >= w - 1) begin
            col_pos = '0;
            row_pos = (r >= h - 1) ? '0 : ROW_W'(r + 1);
        end else begin
            col_pos = COL_W'(c + 1);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------------
    function automatic void check_field(input string name, input logic signed [63:0] expd,
                                        input logic signed [63:0] act);
        if (act !== expd) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
                $error("%s mismatch: expected %0d, actual %0d", name, expd, act);
        end
    endfunction

    always @(posedge aclk) begin
        conv_result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $error("result with no request pending: row %0d col %0d value %0d",
                           m_out_row, m_out_col, m_conv_value);
            end else begin
                exp_res = expected_results.pop_front();
                check_field("conv_value", exp_res.value, m_conv_value);
                check_field("out_row",    exp_res.row,   m_out_row);
                check_field("out_col",    exp_res.col,   m_out_col);
                check_field("frame_end",  exp_res.last,  m_frame_end);
            end
        end
    end

    // receiver back-pressure, redrawn every cycle
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // watchdog: ends a run that stops moving
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    // one pixel request; returns at the edge that accepts it, valid left high
    // so a following request can go out back to back unless idle time is drawn
    task automatic send_pixel(input pix_t pix, input logic fs);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_pixel       <= pix;
        s_frame_start <= fs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        advance_model(pix, fs);
        pixels_sent++;
    endtask

    // stop sending and wait until the pipe is empty
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge aclk);
        case (addr)
            REG_IMAGE_WIDTH:  width_reg   = data[WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: height_reg  = data[HEIGHT_W-1:0];
            REG_COEF_TOP:     coef_reg[0] = data;
            REG_COEF_MIDDLE:  coef_reg[1] = data;
            REG_COEF_BOTTOM:  coef_reg[2] = data;
            default: ;
        endcase
    endtask

    // program all five registers; only called with the pipe idle
    task automatic setup_image(input int unsigned w, input int unsigned h,
                               input coef_row_t top, input coef_row_t mid,
                               input coef_row_t bot);
        write_reg(REG_IMAGE_WIDTH,  CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_COEF_TOP,     top);
        write_reg(REG_COEF_MIDDLE,  mid);
        write_reg(REG_COEF_BOTTOM,  bot);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // biased toward the extremes and the values around zero
    function automatic pix_t rand_pixel();
        case ($urandom_range(9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return pix_t'($urandom_range(16'hFFFF));
        endcase
    endfunction

    function automatic coef_row_t rand_coef_row();
        return {rand_pixel(), rand_pixel(), rand_pixel()};
    endfunction

    // random pixels; frame_start on the first one if asked, then at fs_pct
    task automatic send_run(input int count, input bit first_fs, input int fs_pct);
        for (int i = 0; i < count; i++)
            send_pixel(rand_pixel(), (i == 0 && first_fs) || ($urandom_range(99) < fs_pct));
    endtask

    task automatic send_const(input int count, input pix_t pix, input bit first_fs);
        for (int i = 0; i < count; i++)
            send_pixel(pix, i == 0 && first_fs);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // reset values: 8x8 frame, all-zero kernel
    task automatic test_reset_state();
        send_run(64, 1'b1, 0);
        wait_idle();
    endtask

    // largest positive and negative sums; second frame follows without a
    // frame_start once the row counter wraps
    task automatic test_extreme_products();
        setup_image(3, 3, {3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
        send_const(9, 16'h8000, 1'b1);
        send_const(9, 16'h7FFF, 1'b0);
        wait_idle();
        setup_image(3, 3, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
        send_const(9, 16'h8000, 1'b1);
        wait_idle();
    endtask

    // width and height saturate at the low end, height also at the high end
    // (three rows of a huge frame, so no frame end); the widest frame writes
    // every line store entry that later size changes can reach
    task automatic test_size_clamp();
        setup_image(0, 2, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(9, 1'b1, 0);
        wait_idle();
        setup_image(2, 0, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(9, 1'b1, 0);
        wait_idle();
        setup_image(MAX_RAND_WIDTH, 8191, rand_coef_row(), rand_coef_row(),
                    rand_coef_row());
        send_run(3 * MAX_RAND_WIDTH, 1'b1, 0);
        wait_idle();
    endtask

    // frame_start in mid-frame and frames that start with no flag at all
    task automatic test_frame_restart();
        setup_image(7, 5, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(20, 1'b1, 0);
        send_run(35, 1'b1, 0);
        send_run(35, 1'b0, 0);
        send_run(12, 1'b1, 0);
        send_run(35, 1'b1, 0);
        wait_idle();
    endtask

    // size and kernel changes with the counters in mid-frame
    task automatic test_midframe_config();
        setup_image(9, 6, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(9 * 3 + 4, 1'b1, 0);
        wait_idle();
        // column counter now sits on the new last column
        setup_image(5, 6, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(10, 1'b0, 0);
        wait_idle();
        // row counter beyond the new last row
        setup_image(5, 3, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(20, 1'b0, 0);
        wait_idle();
        setup_image(11, 4, rand_coef_row(), rand_coef_row(), rand_coef_row());
        send_run(30, 1'b0, 0);
        wait_idle();
    endtask

    // random kernels and small sizes; mostly whole frames, some cut short,
    // some without a flag, some with stray frame_start pulses
    task automatic test_random_frames();
        int unsigned w;
        int unsigned h;
        int          target;
        int          frame_len;
        for (int third = 0; third < 3; third++) begin
            case (third)
                0:       begin src_idle_pct = 33; sink_idle_pct = 66; end
                1:       begin src_idle_pct = 66; sink_idle_pct = 33; end
                default: begin src_idle_pct = 0;  sink_idle_pct = 0;  end
            endcase
            target = pixels_sent + RANDOM_ITEMS / 3;
            while (pixels_sent < target) begin
                if ($urandom_range(3) == 0) begin
                    case ($urandom_range(7))
                        0:       w = $urandom_range(2);
                        1:       w = $urandom_range(MAX_RAND_WIDTH, 13);
                        default: w = $urandom_range(12, 3);
                    endcase
                    h = ($urandom_range(5) == 0) ? $urandom_range(2) : $urandom_range(9, 3);
                    wait_idle();
                    setup_image(w, h, rand_coef_row(), rand_coef_row(), rand_coef_row());
                end
                frame_len = eff_width() * eff_height();
                case ($urandom_range(9))
                    6:       send_run($urandom_range(frame_len, 1), 1'b1, 0);
                    7:       send_run(frame_len, 1'b0, 0);
                    8:       send_run(frame_len, 1'b0, 12);
                    default: send_run(frame_len, 1'b1, 0);
                endcase
            end
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_model();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_extreme_products();
        test_size_clamp();
        test_frame_restart();
        test_midframe_config();
        test_random_frames();

        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/c3vs_pkg.sv
rtl/core/c3vs_line_buf.sv
rtl/core/c3vs_mac.sv
rtl/core/conv3x3_valid_stream_top.sv
sim/tb_top.sv
